### hdl/marc_pkg.sv
// Package for the memory access rule checker.
// Holds the table size, the request/response/rule types and the item kind codes.
// No dependencies.
package marc_pkg;

  localparam int unsigned MAX_RULES = 16;
  localparam int unsigned IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_RULES + 1);

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] owner_start;
    logic [63:0] owner_size;
    logic [63:0] region_start;
    logic [63:0] region_size;
    logic [63:0] source_addr;
    logic [63:0] target_addr;
  } req_t;

  typedef struct packed {
    logic       illegal;
    logic       rule_dropped;
    logic [4:0] rule_count;
  } rsp_t;

  // One table entry as stored in the rule memory.
  typedef struct packed {
    logic [63:0] owner_start;
    logic [63:0] owner_size;
    logic [63:0] region_start;
    logic [63:0] region_size;
  } rule_t;

  localparam int unsigned RULE_W = $bits(rule_t);

endpackage

### hdl/memory_access_rule_checker.sv
// Memory access rule checker: rule table in a RAM, sequential scan for checks.
// Depends on marc_pkg and marc_ram.
//
//  port group        dir  handshake                 payload
//  start_i / busy_o  in   start_i & !busy_o          req_i  (marc_pkg::req_t)
//  valid_o           out  one-cycle strobe           rsp_o  (marc_pkg::rsp_t)
//
// Add: the rule is written on acceptance unless the table is full; result strobes next cycle.
// Check: one registered RAM read per held rule; a check on an empty table is answered
// without a scan; the scan stops at the first authorizing rule or after the last held rule.
// busy_o is high for the whole scan; adds never raise busy_o.
// Reset clears the state, the rule count and valid_o; RAM contents are don't-care until written.
// Results cannot be stalled: valid_o is a strobe.
module memory_access_rule_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  marc_pkg::req_t  req_i,
  output logic            valid_o,
  output marc_pkg::rsp_t  rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam int unsigned IDX_W  = marc_pkg::IDX_W;
  localparam int unsigned CNT_W  = marc_pkg::CNT_W;

  function automatic logic in_range(input logic [63:0] addr, input logic [63:0] base,
                                    input logic [63:0] size);
    logic [63:0] diff;
    diff = addr - base;
    return (addr >= base) && (diff <= size);
  endfunction

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 hit_q, hit_d;
  logic [63:0]          src_q, src_d;
  logic [63:0]          tgt_q, tgt_d;
  logic                 valid_q, valid_d;
  marc_pkg::rsp_t       rsp_q, rsp_d;

  logic                 accept;
  logic                 full;
  logic                 we;
  logic [IDX_W-1:0]     raddr;
  marc_pkg::rule_t      wrule;
  marc_pkg::rule_t      rrule;
  logic                 region_hit;
  logic                 owner_hit;
  logic                 last_entry;

  assign accept = start_i && !busy_o;
  assign full   = (count_q >= CNT_W'(marc_pkg::MAX_RULES));
  assign we     = accept && (req_i.kind == marc_pkg::KIND_ADD) && !full;

  assign wrule.owner_start  = req_i.owner_start;
  assign wrule.owner_size   = req_i.owner_size;
  assign wrule.region_start = req_i.region_start;
  assign wrule.region_size  = req_i.region_size;

  assign raddr = (state_q == ST_SCAN) ? idx_q + IDX_W'(1) : '0;

  marc_ram #(
    .WIDTH (marc_pkg::RULE_W),
    .DEPTH (marc_pkg::MAX_RULES)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wrule),
    .raddr_i (raddr),
    .rdata_o (rrule)
  );

  // rrule holds entry idx_q while scanning
  assign region_hit = in_range(tgt_q, rrule.region_start, rrule.region_size);
  assign owner_hit  = in_range(src_q, rrule.owner_start, rrule.owner_size);
  assign last_entry = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    src_d   = src_q;
    tgt_d   = tgt_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == marc_pkg::KIND_ADD) begin
            if (!full) begin
              count_d = count_q + CNT_W'(1);
            end
            valid_d            = 1'b1;
            rsp_d.illegal      = 1'b0;
            rsp_d.rule_dropped = full;
            rsp_d.rule_count   = 5'(count_d);
          end else if (count_q == '0) begin
            valid_d            = 1'b1;
            rsp_d.illegal      = 1'b0;
            rsp_d.rule_dropped = 1'b0;
            rsp_d.rule_count   = 5'(count_q);
          end else begin
            src_d   = req_i.source_addr;
            tgt_d   = req_i.target_addr;
            idx_d   = '0;
            hit_d   = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        hit_d = hit_q || region_hit;
        idx_d = idx_q + IDX_W'(1);
        if ((region_hit && owner_hit) || last_entry) begin
          valid_d            = 1'b1;
          rsp_d.illegal      = (hit_q || region_hit) && !(region_hit && owner_hit);
          rsp_d.rule_dropped = 1'b0;
          rsp_d.rule_count   = 5'(count_q);
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    hit_q <= hit_d;
    src_q <= src_d;
    tgt_q <= tgt_d;
    rsp_q <= rsp_d;
  end

  assign busy_o  = (state_q == ST_SCAN);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(marc_pkg::MAX_RULES))
    else $error("rule count above table size");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.kind == marc_pkg::KIND_ADD) && full
    |=> valid_o && rsp_o.rule_dropped && $stable(count_q))
    else $error("add on full table not dropped");

  a_empty_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.kind == marc_pkg::KIND_CHECK) && (count_q == '0)
    |=> valid_o && !rsp_o.illegal)
    else $error("check on empty table not legal");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(we))
    else $error("rule count changed without a rule write");

  a_scan_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !valid_o)
    else $error("unexpected result during scan");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(rsp_o.illegal && rsp_o.rule_dropped))
    else $error("illegal and rule_dropped both set");

endmodule

### hdl/marc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the rule table. No dependencies.
module marc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### verif/memory_access_rule_checker_tb.sv
// Testbench for memory_access_rule_checker: directed empty-table and rule-bound cases, then
// random rule fills and boundary-targeted access checks, scored against an in-bench table model.
// Depends on marc_pkg and the checker RTL.
module memory_access_rule_checker_tb;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  marc_pkg::req_t  req_i;
  logic            valid_o;
  marc_pkg::rsp_t  rsp_o;

  // Shadow of the rule table, updated at each accepted add that is not dropped
  marc_pkg::rule_t rule_tab [marc_pkg::MAX_RULES];
  int unsigned     rules_held;

  marc_pkg::rsp_t  pending_results [$];
  marc_pkg::rsp_t  exp_rsp;
  int              err_cnt;
  int              idle_pct;
  int              n_add, n_drop, n_check, n_illegal;

  memory_access_rule_checker u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Inclusive bound, start <= addr <= start + size, no wrap
  function automatic bit in_range(logic [63:0] addr, logic [63:0] base, logic [63:0] size);
    return (addr >= base) && ((addr - base) <= size);
  endfunction

  function automatic marc_pkg::rsp_t predict_rule_table(input marc_pkg::req_t r);
    marc_pkg::rsp_t res;
    bit             hit;
    bit             allowed;
    res     = '0;
    hit     = 1'b0;
    allowed = 1'b0;
    if (r.kind == marc_pkg::KIND_ADD) begin
      n_add++;
      if (rules_held < marc_pkg::MAX_RULES) begin
        rule_tab[rules_held] = '{r.owner_start, r.owner_size, r.region_start, r.region_size};
        rules_held++;
      end else begin
        res.rule_dropped = 1'b1;
        n_drop++;
      end
    end else begin
      n_check++;
      for (int i = 0; i < rules_held; i++) begin
        if (!allowed && in_range(r.target_addr, rule_tab[i].region_start,
                                 rule_tab[i].region_size)) begin
          hit = 1'b1;
          if (in_range(r.source_addr, rule_tab[i].owner_start, rule_tab[i].owner_size))
            allowed = 1'b1;
        end
      end
      res.illegal = hit && !allowed;
      if (res.illegal) n_illegal++;
    end
    res.rule_count = rules_held[4:0];
    return res;
  endfunction

  function automatic marc_pkg::req_t make_add(logic [63:0] os, logic [63:0] osz,
                                              logic [63:0] rs, logic [63:0] rsz);
    marc_pkg::req_t r;
    r = '{marc_pkg::KIND_ADD, os, osz, rs, rsz, rand64(), rand64()};
    return r;
  endfunction

  function automatic marc_pkg::req_t make_check(logic [63:0] src, logic [63:0] tgt);
    marc_pkg::req_t r;
    r = '{marc_pkg::KIND_CHECK, rand64(), rand64(), rand64(), rand64(), src, tgt};
    return r;
  endfunction

  // Address at or just around the bounds of a region, inside it, or anywhere at random
  function automatic logic [63:0] pick_near(logic [63:0] base, logic [63:0] size);
    logic [64:0] last;
    logic [64:0] span;
    last = {1'b0, base} + {1'b0, size};
    span = {1'b0, size} + 65'd1;
    case ($urandom_range(0, 5))
      0: return base;
      1: return last[64] ? '1 : last[63:0];
      2: return base - 64'd1;
      3: return last[64] ? rand64() : last[63:0] + 64'd1;
      4: return base + 64'({1'b0, rand64()} % span);
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] gen_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 64'($urandom_range(1, 4096));
      2: return rand64();
      default: return rand64() >> $urandom_range(1, 63);
    endcase
  endfunction

  function automatic marc_pkg::req_t gen_rule();
    logic [63:0] rs;
    logic [63:0] os;
    int          k;
    rs = rand64();
    os = rand64();
    if (rules_held > 0 && $urandom_range(0, 1) == 1) begin
      // overlap an existing region so scans see several hits
      k  = $urandom_range(0, rules_held - 1);
      rs = pick_near(rule_tab[k].region_start, rule_tab[k].region_size);
    end
    return make_add(os, gen_size(), rs, gen_size());
  endfunction

  function automatic marc_pkg::req_t gen_check();
    logic [63:0] src;
    logic [63:0] tgt;
    int          k;
    int          j;
    if (rules_held == 0 || $urandom_range(0, 99) < 15)
      return make_check(rand64(), rand64());
    k   = $urandom_range(0, rules_held - 1);
    j   = $urandom_range(0, rules_held - 1);
    tgt = pick_near(rule_tab[k].region_start, rule_tab[k].region_size);
    case ($urandom_range(0, 3))
      0, 1: src = pick_near(rule_tab[k].owner_start, rule_tab[k].owner_size);
      2: src = pick_near(rule_tab[j].owner_start, rule_tab[j].owner_size);
      default: src = rand64();
    endcase
    return make_check(src, tgt);
  endfunction

  // Each cycle the sender idles with probability idle_pct percent
  task automatic send_item(input marc_pkg::req_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    req_i   = r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results = {pending_results, predict_rule_table(r)};
  endtask

  task automatic stop_and_drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(make_check('0, '0));
    send_item(make_check('1, '1));
  endtask

  task automatic test_rule_bounds();
    send_item(make_add(64'h1000, 64'hFF, 64'h8000, 64'hFFF));
    send_item(make_add(64'h2000, '0, 64'hA000, '0));                 // zero-size regions
    send_item(make_add(64'hFFFF_FFFF_FFFF_FFF0, '1,
                       64'hFFFF_FFFF_FFFF_FF00, '1));                // past top of space
    send_item(make_add(64'h3000, 64'h10, 64'h8800, 64'h100));        // nested in the first
    send_item(make_check(64'h10FF, 64'h8000));
    send_item(make_check(64'h0FFF, 64'h8FFF));
    send_item(make_check('0, 64'h9000));
    send_item(make_check(64'h2000, 64'hA000));
    send_item(make_check(64'h2001, 64'hA000));
    send_item(make_check(64'h3005, 64'h8850));                       // second hit authorizes
    send_item(make_check('1, '1));
    send_item(make_check(64'h1000, 64'hFFFF_FFFF_FFFF_FF00));
    send_item(make_check(64'h1234, 64'h7FFF));
  endtask

  // Fill the table with two checks after each add, then offer two adds to the full table
  task automatic test_table_fill();
    while (rules_held < marc_pkg::MAX_RULES) begin
      send_item(gen_rule());
      send_item(gen_check());
      send_item(gen_check());
    end
    send_item(gen_rule());
    send_item(gen_rule());
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) send_item(gen_rule());
      else send_item(gen_check());
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: illegal=%0b dropped=%0b count=%0d",
                   rsp_o.illegal, rsp_o.rule_dropped, rsp_o.rule_count);
      end else begin
        exp_rsp = pending_results.pop_front();
        if (rsp_o.illegal !== exp_rsp.illegal || rsp_o.rule_dropped !== exp_rsp.rule_dropped
            || rsp_o.rule_count !== exp_rsp.rule_count) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp illegal=%0b dropped=%0b count=%0d, got %0b %0b %0d",
                     exp_rsp.illegal, exp_rsp.rule_dropped, exp_rsp.rule_count,
                     rsp_o.illegal, rsp_o.rule_dropped, rsp_o.rule_count);
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_i      = '0;
    rules_held = 0;
    err_cnt    = 0;
    idle_pct   = 0;
    n_add      = 0;
    n_drop     = 0;
    n_check    = 0;
    n_illegal  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_rule_bounds();
    idle_pct = 37;
    test_table_fill();
    test_random(600);
    idle_pct = 70;
    test_random(600);
    stop_and_drain();  // sender holds off until every transaction has returned
    idle_pct = 0;
    test_random(560);
    stop_and_drain();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) err_cnt++;

    $display("covered %0d rule adds (%0d dropped on a full table) and %0d access checks",
             n_add, n_drop, n_check);
    $display("%0d checks flagged illegal; sender idle at 37, 70 and 0 percent", n_illegal);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
hdl/marc_pkg.sv
hdl/marc_ram.sv
hdl/memory_access_rule_checker.sv
verif/memory_access_rule_checker_tb.sv
